[rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define HEU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define HEU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/heu_pkg.sv]
package heu_pkg;

    localparam int CAP_W           = 16;
    localparam int CHAR_W          = 8;
    localparam int MAX_BYTES       = 4;
    localparam int NB_W            = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [CAP_W-1:0]  CAP_RESET      = 16'd33;
    localparam logic [CHAR_W-1:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CHAR_X         = 8'h78;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_BSLASH = 2'd1,
        PH_X      = 2'd2,
        PH_HEX    = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TRUNC    = 2'd1,
        STATUS_ZERO_CAP = 2'd2
    } status_t;

    // One classified input transaction: candidate bytes in order, then optional status.
    typedef struct packed {
        logic [MAX_BYTES-1:0][CHAR_W-1:0] bytes;
        logic [NB_W-1:0]                  n_bytes;
        logic                             eos;
    } cmd_t;

    function automatic logic is_hex(input logic [CHAR_W-1:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
                 (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end
        hex_val = d[3:0];
    endfunction

endpackage

[rtl/heu_front.sv]
module heu_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [heu_pkg::CHAR_W-1:0] s_tdata,
    input  logic                       s_tlast,
    input  logic                       s_tuser,
    input  logic                       q_full,
    output logic                       q_push,
    output heu_pkg::cmd_t              q_cmd
);

    heu_pkg::phase_t            phase_reg, phase_next, ph_mid;
    logic [heu_pkg::CHAR_W-1:0] held_reg, held_next, held_mid;
    logic                       accept;
    logic                       adv;
    logic                       dec;
    logic [heu_pkg::NB_W-1:0]   nb;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        adv = 1'b0;
        dec = 1'b0;
        case (phase_reg)
            heu_pkg::PH_BSLASH: adv = (s_tdata == heu_pkg::CHAR_X);
            heu_pkg::PH_X:      adv = heu_pkg::is_hex(s_tdata);
            heu_pkg::PH_HEX:    dec = heu_pkg::is_hex(s_tdata);
            default:            ;
        endcase
    end

    // next state
    always_comb begin
        ph_mid   = phase_reg;
        held_mid = held_reg;
        if (s_tuser) begin
            if (adv) begin
                ph_mid = (phase_reg == heu_pkg::PH_BSLASH) ? heu_pkg::PH_X : heu_pkg::PH_HEX;
                if (phase_reg == heu_pkg::PH_X) begin
                    held_mid = s_tdata;
                end
            end else if (dec) begin
                ph_mid   = heu_pkg::PH_IDLE;
                held_mid = '0;
            end else begin
                ph_mid   = (s_tdata == heu_pkg::CHAR_BACKSLASH) ? heu_pkg::PH_BSLASH
                                                                 : heu_pkg::PH_IDLE;
                held_mid = '0;
            end
        end
        phase_next = phase_reg;
        held_next  = held_reg;
        if (accept) begin
            phase_next = s_tlast ? heu_pkg::PH_IDLE : ph_mid;
            held_next  = s_tlast ? '0 : held_mid;
        end
    end

    // outputs: ordered candidate bytes for the back end
    always_comb begin
        q_cmd = '0;
        nb    = '0;
        if (s_tuser) begin
            if (dec) begin
                q_cmd.bytes[nb[1:0]] = {heu_pkg::hex_val(held_reg), heu_pkg::hex_val(s_tdata)};
                nb = nb + 3'd1;
            end else if (!adv) begin
                if (phase_reg != heu_pkg::PH_IDLE) begin
                    q_cmd.bytes[nb[1:0]] = heu_pkg::CHAR_BACKSLASH;
                    nb = nb + 3'd1;
                end
                if (phase_reg == heu_pkg::PH_X || phase_reg == heu_pkg::PH_HEX) begin
                    q_cmd.bytes[nb[1:0]] = heu_pkg::CHAR_X;
                    nb = nb + 3'd1;
                end
                if (phase_reg == heu_pkg::PH_HEX) begin
                    q_cmd.bytes[nb[1:0]] = held_reg;
                    nb = nb + 3'd1;
                end
                if (s_tdata != heu_pkg::CHAR_BACKSLASH) begin
                    q_cmd.bytes[nb[1:0]] = s_tdata;
                    nb = nb + 3'd1;
                end
            end
        end
        if (s_tlast) begin
            if (ph_mid != heu_pkg::PH_IDLE) begin
                q_cmd.bytes[nb[1:0]] = heu_pkg::CHAR_BACKSLASH;
                nb = nb + 3'd1;
            end
            if (ph_mid == heu_pkg::PH_X || ph_mid == heu_pkg::PH_HEX) begin
                q_cmd.bytes[nb[1:0]] = heu_pkg::CHAR_X;
                nb = nb + 3'd1;
            end
            if (ph_mid == heu_pkg::PH_HEX) begin
                q_cmd.bytes[nb[1:0]] = held_mid;
                nb = nb + 3'd1;
            end
            q_cmd.eos = 1'b1;
        end
        q_cmd.n_bytes = nb;
        q_push        = accept && ((nb != '0) || s_tlast);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= heu_pkg::PH_IDLE;
            held_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

[rtl/heu_queue.sv]
module heu_queue #(
    parameter int DEPTH = heu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  heu_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output heu_pkg::cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    heu_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (cnt_reg == CNT_FULL);
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[rtl/heu_back.sv]
module heu_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [heu_pkg::CAP_W-1:0]  out_capacity,
    input  logic                       head_valid,
    input  heu_pkg::cmd_t              head,
    output logic                       pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,
    output logic                       m_tlast,
    output logic                       m_tuser
);

    logic [heu_pkg::CAP_W-1:0]  count_reg, count_next;
    logic                       ovf_reg, ovf_next;
    logic [heu_pkg::NB_W-1:0]   idx_reg, idx_next;
    logic                       valid_reg, valid_next;
    logic [heu_pkg::CHAR_W-1:0] char_reg, char_next;
    logic                       has_reg, has_next;
    logic                       eos_reg, eos_next;
    heu_pkg::status_t           status_reg, status_next;
    logic [heu_pkg::CAP_W-1:0]  limit;
    logic                       step;
    logic                       is_byte;

    assign limit   = (out_capacity == '0) ? '0 : out_capacity - 16'd1;
    assign step    = head_valid && (!valid_reg || m_tready);
    assign is_byte = (idx_reg < head.n_bytes);

    always_comb begin
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        idx_next    = idx_reg;
        valid_next  = m_tready ? 1'b0 : valid_reg;
        char_next   = char_reg;
        has_next    = has_reg;
        eos_next    = eos_reg;
        status_next = status_reg;
        pop         = 1'b0;
        if (step) begin
            if (is_byte) begin
                if (count_reg < limit) begin
                    valid_next  = 1'b1;
                    char_next   = head.bytes[idx_reg[1:0]];
                    has_next    = 1'b1;
                    eos_next    = 1'b0;
                    status_next = heu_pkg::STATUS_OK;
                    count_next  = count_reg + 16'd1;
                end else begin
                    ovf_next = 1'b1;
                end
                if ((idx_reg + 3'd1 == head.n_bytes) && !head.eos) begin
                    pop      = 1'b1;
                    idx_next = '0;
                end else begin
                    idx_next = idx_reg + 3'd1;
                end
            end else begin
                valid_next = 1'b1;
                char_next  = '0;
                has_next   = 1'b0;
                eos_next   = 1'b1;
                if (out_capacity == '0) begin
                    status_next = heu_pkg::STATUS_ZERO_CAP;
                end else if (ovf_reg) begin
                    status_next = heu_pkg::STATUS_TRUNC;
                end else begin
                    status_next = heu_pkg::STATUS_OK;
                end
                count_next = '0;
                ovf_next   = 1'b0;
                pop        = 1'b1;
                idx_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        char_reg   <= char_next;
        has_reg    <= has_next;
        eos_reg    <= eos_next;
        status_reg <= status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, status_reg, char_reg};
    assign m_tlast  = eos_reg;
    assign m_tuser  = has_reg;

endmodule

[rtl/hex_escape_unescaper.sv]
// Backslash-x hex escape decoder. One source character is taken per cycle on the
// slave side; each complete "\xHH" (either letter case) leaves as one byte, any other
// character passes through, and a broken or unfinished escape comes out literally.
// Every string ends with one status transaction (tlast high, tuser low): ok,
// truncated when more than out_capacity-1 bytes were produced, or zero capacity.
// The front end classifies each character into up to four candidate bytes plus the
// status; a QUEUE_DEPTH-entry queue holds these for the back end, which applies the
// capacity limit and presents one transaction per cycle from its output register
// while m_tready is high. Input is taken every cycle while the queue has room; a
// character that releases a held escape is worked off by the back end one byte at
// a time (up to four, then the status). out_capacity resets to 33; the user must
// write it only while the block is idle, as the block does not enforce this.
module hex_escape_unescaper #(
    parameter int QUEUE_DEPTH = heu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [heu_pkg::CAP_W-1:0]  cfg_wr_data,   // out_capacity
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,       // [7:0] in_char
    input  logic                       s_tlast,
    input  logic                       s_tuser,       // [0] char_valid
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,       // [7:0] out_char, [9:8] status
    output logic                       m_tlast,
    output logic                       m_tuser        // [0] has_char
);

    logic [heu_pkg::CAP_W-1:0] cap_reg;
    logic                      q_full;
    logic                      q_push;
    heu_pkg::cmd_t             q_cmd;
    logic                      q_pop;
    logic                      q_head_valid;
    heu_pkg::cmd_t             q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= heu_pkg::CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    heu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    heu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    heu_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .out_capacity (cap_reg),
        .head_valid   (q_head_valid),
        .head         (q_head),
        .pop          (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

endmodule

[rtl/heu_checker.sv]
`include "assert_macros.svh"

module heu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    logic [7:0] out_char;
    logic [1:0] out_status;
    logic       out_known;
    logic       char_clear;
    logic       status_clear;

    assign out_char     = m_tdata[7:0];
    assign out_status   = m_tdata[9:8];
    assign char_clear   = (out_char == 8'd0);
    assign status_clear = (out_status == heu_pkg::STATUS_OK);
    assign out_known    = ((out_status == heu_pkg::STATUS_OK) ||
                           (out_status == heu_pkg::STATUS_TRUNC) ||
                           (out_status == heu_pkg::STATUS_ZERO_CAP)) &&
                          (m_tdata[15:10] == 6'd0) && (m_tuser || m_tlast);

    `HEU_ASSERT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped")
    `HEU_ASSERT(a_status_no_char, aclk, aresetn, m_tvalid && m_tlast |-> !m_tuser && char_clear, "status with byte")
    `HEU_ASSERT(a_byte_no_status, aclk, aresetn, m_tvalid && m_tuser |-> !m_tlast && status_clear, "byte with status")
    `HEU_ASSERT(a_status_code, aclk, aresetn, m_tvalid |-> out_known, "bad result code")
    `HEU_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "output valid straight after reset")

endmodule

bind hex_escape_unescaper heu_checker u_heu_checker (.*);

[verif/tb_hex_escape_unescaper.sv]
`timescale 1ns / 100ps

module tb_hex_escape_unescaper;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYC   = 10;
    localparam int RAND_ITEMS   = 500;
    localparam int MAX_REPORTS  = 10;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;

    typedef struct {
        logic [7:0] ch;
        logic       vld;
        logic       lst;
    } src_item_t;

    typedef struct {
        logic [7:0]       ch;
        logic             has_ch;
        logic             eos;
        heu_pkg::status_t st;
    } dec_result_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic        s_tlast     = 1'b0;
    logic        s_tuser     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    src_item_t   src_queue[$];
    dec_result_t expected_out[$];

    // decoder state as predicted
    heu_pkg::phase_t dec_phase = heu_pkg::PH_IDLE;
    logic [7:0]      dec_held  = '0;
    logic [15:0]     dec_count = '0;
    logic            dec_ovf   = 1'b0;
    logic [15:0]     cap_q     = heu_pkg::CAP_RESET;

    int  send_idle_pct = 15;
    int  recv_idle_pct = 88;
    int  src_count     = 0;
    int  mismatches    = 0;
    int  cycle_cnt     = 0;
    bit  in_taken      = 1'b0;

    hex_escape_unescaper DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    always #4 aclk = ~aclk;

    // [4] is a hex digit, [3:0] its value
    function automatic logic [4:0] hex_lookup(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return {1'b1, c[3:0]};
        end else if ((c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F)) begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    function automatic void push_byte(input logic [7:0] c);
        logic [15:0] limit;
        dec_result_t r;
        limit = (cap_q == 16'd0) ? 16'd0 : cap_q - 16'd1;
        if (dec_count < limit) begin
            r.ch     = c;
            r.has_ch = 1'b1;
            r.eos    = 1'b0;
            r.st     = heu_pkg::STATUS_OK;
            expected_out.push_back(r);
            dec_count = dec_count + 16'd1;
        end else begin
            dec_ovf = 1'b1;
        end
    endfunction

    function automatic void flush_escape();
        if (dec_phase >= heu_pkg::PH_BSLASH) push_byte(heu_pkg::CHAR_BACKSLASH);
        if (dec_phase >= heu_pkg::PH_X) push_byte(heu_pkg::CHAR_X);
        if (dec_phase >= heu_pkg::PH_HEX) push_byte(dec_held);
        dec_phase = heu_pkg::PH_IDLE;
        dec_held  = '0;
    endfunction

    function automatic void decode_char(input logic [7:0] c);
        logic [4:0] lo;
        logic [4:0] hi;
        logic       done;
        lo   = hex_lookup(c);
        done = 1'b0;
        case (dec_phase)
            heu_pkg::PH_BSLASH: begin
                if (c == heu_pkg::CHAR_X) begin
                    dec_phase = heu_pkg::PH_X;
                    done      = 1'b1;
                end
            end
            heu_pkg::PH_X: begin
                if (lo[4]) begin
                    dec_held  = c;
                    dec_phase = heu_pkg::PH_HEX;
                    done      = 1'b1;
                end
            end
            heu_pkg::PH_HEX: begin
                if (lo[4]) begin
                    hi        = hex_lookup(dec_held);
                    dec_phase = heu_pkg::PH_IDLE;
                    dec_held  = '0;
                    push_byte({hi[3:0], lo[3:0]});
                    done      = 1'b1;
                end
            end
            default: ;
        endcase
        if (!done) begin
            flush_escape();
            if (c == heu_pkg::CHAR_BACKSLASH) dec_phase = heu_pkg::PH_BSLASH;
            else push_byte(c);
        end
    endfunction

    function automatic void decode_item(input logic [7:0] c, input logic vld,
                                        input logic lst);
        dec_result_t r;
        if (vld) decode_char(c);
        if (lst) begin
            flush_escape();
            r.ch     = '0;
            r.has_ch = 1'b0;
            r.eos    = 1'b1;
            if (cap_q == 16'd0) r.st = heu_pkg::STATUS_ZERO_CAP;
            else if (dec_ovf) r.st = heu_pkg::STATUS_TRUNC;
            else r.st = heu_pkg::STATUS_OK;
            expected_out.push_back(r);
            dec_count = '0;
            dec_ovf   = 1'b0;
        end
    endfunction

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
            // hold until accepted
        end else if (src_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            src_item_t it;
            it = src_queue.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= it.ch;
            s_tuser  <= it.vld;
            s_tlast  <= it.lst;
        end else begin
            s_tvalid <= 1'b0;
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        dec_result_t e;
        in_taken = aresetn && s_tvalid && s_tready;
        if (in_taken) decode_item(s_tdata, s_tuser, s_tlast);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_out.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected transaction: ch=%02h st=%0d last=%0b user=%0b",
                             m_tdata[7:0], m_tdata[9:8], m_tlast, m_tuser);
            end else begin
                e = expected_out.pop_front();
                if (m_tdata[7:0] !== e.ch || m_tdata[9:8] !== e.st ||
                    m_tlast !== e.eos || m_tuser !== e.has_ch) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch cyc %0d: exp %02h/%0d/%0b/%0b got %02h/%0d/%0b/%0b",
                                 cycle_cnt, e.ch, e.st, e.eos, e.has_ch,
                                 m_tdata[7:0], m_tdata[9:8], m_tlast, m_tuser);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic queue_item(input logic [7:0] c, input logic vld, input logic lst);
        src_item_t it;
        it.ch  = c;
        it.vld = vld;
        it.lst = lst;
        src_queue.push_back(it);
        if (vld || lst) src_count++;
    endtask

    task automatic queue_char(input logic [7:0] c);
        queue_item(c, 1'b1, 1'b0);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_char(s[i]);
    endtask

    task automatic wait_drained();
        while (src_queue.size() != 0 || s_tvalid || expected_out.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [15:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cap_q = v;
    endtask

    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(15);
        if (v < 10) return CH_ZERO + 8'(v);
        return ($urandom_range(1) ? CH_LC_A : CH_UC_A) + 8'(v - 10);
    endfunction

    function automatic logic [15:0] pick_capacity();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 16'd0;
        if (r < 20) return 16'd1;
        if (r < 30) return 16'hFFFF;
        return 16'($urandom_range(2, 16));
    endfunction

    task automatic queue_random_string();
        int n_tok;
        int r;
        int k;
        n_tok = $urandom_range(1, 12);
        for (int t = 0; t < n_tok; t++) begin
            r = $urandom_range(99);
            if (r < 35) begin
                queue_char(8'($urandom_range(255)));
            end else if (r < 70) begin
                queue_char(heu_pkg::CHAR_BACKSLASH);
                queue_char(heu_pkg::CHAR_X);
                queue_char(rand_hex());
                queue_char(rand_hex());
            end else if (r < 85) begin
                // escape prefix, then a random character (usually a broken escape)
                k = $urandom_range(1, 3);
                queue_char(heu_pkg::CHAR_BACKSLASH);
                if (k >= 2) queue_char(heu_pkg::CHAR_X);
                if (k >= 3) queue_char(rand_hex());
                queue_char(8'($urandom_range(255)));
            end else if (r < 92) begin
                queue_item(8'($urandom_range(255)), 1'b0, 1'b0);
            end else begin
                queue_char(heu_pkg::CHAR_BACKSLASH);
            end
        end
        queue_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    endtask

    initial begin
        int rand_base;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, reset capacity
        queue_text("\\xfF");
        queue_text("\\x4g");
        queue_text("\\\\x7e");
        queue_char(8'h00);
        queue_char(8'hFF);
        queue_item(8'hA5, 1'b0, 1'b0);
        queue_text("\\x");
        queue_item(8'h00, 1'b0, 1'b1);
        wait_drained();

        write_capacity(16'd0);
        queue_item(8'h61, 1'b1, 1'b1);
        wait_drained();

        // capacity raised while an escape is open
        write_capacity(16'd3);
        queue_text("ab\\x5");
        wait_drained();
        write_capacity(16'hFFFF);
        queue_item(8'h7A, 1'b1, 1'b1);
        wait_drained();

        rand_base = src_count;
        while (src_count - rand_base < RAND_ITEMS) begin
            if (src_count - rand_base < RAND_ITEMS / 3) begin
                send_idle_pct = 15;
                recv_idle_pct = 88;
            end else if (src_count - rand_base < 2 * RAND_ITEMS / 3) begin
                send_idle_pct = 88;
                recv_idle_pct = 15;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_capacity(pick_capacity());
            repeat ($urandom_range(1, 4)) queue_random_string();
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[hex_escape_unescaper.f]
+incdir+rtl
rtl/heu_pkg.sv
rtl/heu_front.sv
rtl/heu_queue.sv
rtl/heu_back.sv
rtl/hex_escape_unescaper.sv
rtl/heu_checker.sv
verif/tb_hex_escape_unescaper.sv
